// ----- rtl/segment_circle_first_hit_core_macros.svh -----
// assertion macros for the segment circle first hit core checker
`ifndef SEGMENT_CIRCLE_FIRST_HIT_CORE_MACROS_SVH
`define SEGMENT_CIRCLE_FIRST_HIT_CORE_MACROS_SVH

// same-cycle implication
`define SCFH_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfh check failed");

// implication after a fixed number of cycles
`define SCFH_ASSERT_DELAY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("scfh latency check failed");

`endif

// ----- rtl/scfh_pkg.sv -----
// shared types, widths and step functions of the segment circle first hit core
package scfh_pkg;

    localparam int CW    = 16;            // coordinate width
    localparam int RW    = CW - 1;        // radius width
    localparam int DW    = CW + 1;        // coordinate difference width
    localparam int PW    = 2 * DW;        // difference product width
    localparam int L2W   = PW;            // squared length width
    localparam int DOTW  = PW + 1;        // dot and cross width
    localparam int ACW   = 2 * CW;        // cross magnitude limit for a hit
    localparam int R2W   = 2 * RW;        // squared radius width
    localparam int RADW  = 2 * ACW;       // radicand width
    localparam int SQW   = ACW;           // root width
    localparam int KW    = DOTW + 1;      // projection offset width
    localparam int MW    = KW + DW;       // scaled offset width
    localparam int NW    = MW + 2;        // dividend width
    localparam int DENW  = L2W + 1;       // divisor width
    localparam int QW    = DW + 1;        // quotient width, bounded by |u| + r
    localparam int FXW   = CW + 4;        // unsaturated point width

    localparam int FRONT_STAGES = 6;
    localparam int SQRT_PER     = 2;
    localparam int SQRT_STAGES  = SQW / SQRT_PER;
    localparam int MID_STAGES   = 3;
    localparam int DIV_PER      = 2;
    localparam int DIV_STAGES   = QW / DIV_PER;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + MID_STAGES + DIV_STAGES + 1;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] centre_x;
        logic signed [CW-1:0] centre_y;
        logic        [RW-1:0] radius;
    } in_word_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
    } out_word_t;

    typedef struct packed {
        logic signed [CW-1:0]   sx;
        logic signed [CW-1:0]   sy;
        logic signed [CW-1:0]   ex;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dy;
        logic signed [DOTW-1:0] dot;
        logic        [L2W-1:0]  l2;
        logic                   cand;
        logic                   chk;
    } front_side_t;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic                 negx;
        logic                 negy;
        logic                 cand;
        logic                 chk;
    } back_side_t;

    typedef struct packed {
        logic [RADW-1:0] v;
        logic [RADW-1:0] res;
    } sqrt_state_t;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [QW-1:0] q;
    } div_state_t;

    // one digit of the bitwise square root
    function automatic sqrt_state_t sqrt_step(sqrt_state_t s, int idx);
        logic [RADW-1:0] bitv;
        logic [RADW-1:0] trial;
        sqrt_state_t     n;
        bitv  = RADW'(1) << (RADW - 2 - 2 * idx);
        trial = s.res + bitv;
        if (s.v >= trial) begin
            n.v   = s.v - trial;
            n.res = (s.res >> 1) + bitv;
        end else begin
            n.v   = s.v;
            n.res = s.res >> 1;
        end
        return n;
    endfunction

    // one quotient bit of the restoring divide
    function automatic div_state_t div_step(div_state_t s, logic [DENW-1:0] d, int idx);
        logic [NW-1:0] sub;
        div_state_t    n;
        sub = NW'(d) << idx;
        if (s.rem >= sub) begin
            n.rem = s.rem - sub;
            n.q   = {s.q[QW-2:0], 1'b1};
        end else begin
            n.rem = s.rem;
            n.q   = {s.q[QW-2:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic signed [CW-1:0] sat_coord(logic signed [FXW-1:0] v);
        logic signed [FXW-1:0] hi;
        logic signed [FXW-1:0] lo;
        hi = FXW'((2 ** (CW - 1)) - 1);
        lo = ~hi;
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

endpackage

// ----- rtl/scfh_front.sv -----
// front stages: differences, products, length, dot, cross and radicand
module scfh_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  scfh_pkg::in_word_t            in_word,
    output logic                          out_valid,
    output logic [scfh_pkg::RADW-1:0]     out_rad,
    output scfh_pkg::front_side_t         out_side
);
    import scfh_pkg::*;

    logic [FRONT_STAGES-1:0] valid_reg;

    // stage 1
    in_word_t w1_reg;
    // stage 2
    logic signed [CW-1:0] sx2_reg, sy2_reg, ex2_reg;
    logic        [RW-1:0] r2_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg, ux2_reg, uy2_reg;
    // stage 3
    logic signed [CW-1:0] sx3_reg, sy3_reg, ex3_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic signed [PW-1:0] pxx3_reg, pyy3_reg, pdu3_reg, pdv3_reg, pcx3_reg, pcy3_reg;
    logic       [R2W-1:0] rr3_reg;
    // stage 4
    logic signed [CW-1:0]   sx4_reg, sy4_reg, ex4_reg;
    logic signed [DW-1:0]   dx4_reg, dy4_reg;
    logic        [L2W-1:0]  l24_reg;
    logic signed [DOTW-1:0] dot4_reg;
    logic        [DOTW-1:0] acrs4_reg;
    logic        [R2W-1:0]  rr4_reg;
    // stage 5
    logic signed [CW-1:0]   sx5_reg, sy5_reg, ex5_reg;
    logic signed [DW-1:0]   dx5_reg, dy5_reg;
    logic        [L2W-1:0]  l25_reg;
    logic signed [DOTW-1:0] dot5_reg;
    logic        [RADW-1:0] c25_reg, r2l5_reg;
    logic                   far5_reg, zero5_reg;
    // stage 6
    logic [RADW-1:0] rad6_reg;
    front_side_t     side6_reg;

    logic signed [DOTW-1:0] crs4_next;
    logic                   lt5, eq5;

    assign crs4_next = {pcx3_reg[PW-1], pcx3_reg} - {pcy3_reg[PW-1], pcy3_reg};
    assign lt5       = c25_reg < r2l5_reg;
    assign eq5       = c25_reg == r2l5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg   <= in_word;

        sx2_reg  <= w1_reg.start_x;
        sy2_reg  <= w1_reg.start_y;
        ex2_reg  <= w1_reg.end_x;
        r2_reg   <= w1_reg.radius;
        dx2_reg  <= {w1_reg.end_x[CW-1], w1_reg.end_x} - {w1_reg.start_x[CW-1], w1_reg.start_x};
        dy2_reg  <= {w1_reg.end_y[CW-1], w1_reg.end_y} - {w1_reg.start_y[CW-1], w1_reg.start_y};
        ux2_reg  <= {w1_reg.centre_x[CW-1], w1_reg.centre_x}
                    - {w1_reg.start_x[CW-1], w1_reg.start_x};
        uy2_reg  <= {w1_reg.centre_y[CW-1], w1_reg.centre_y}
                    - {w1_reg.start_y[CW-1], w1_reg.start_y};

        sx3_reg  <= sx2_reg;
        sy3_reg  <= sy2_reg;
        ex3_reg  <= ex2_reg;
        dx3_reg  <= dx2_reg;
        dy3_reg  <= dy2_reg;
        pxx3_reg <= PW'(dx2_reg) * PW'(dx2_reg);
        pyy3_reg <= PW'(dy2_reg) * PW'(dy2_reg);
        pdu3_reg <= PW'(dx2_reg) * PW'(ux2_reg);
        pdv3_reg <= PW'(dy2_reg) * PW'(uy2_reg);
        pcx3_reg <= PW'(dx2_reg) * PW'(uy2_reg);
        pcy3_reg <= PW'(dy2_reg) * PW'(ux2_reg);
        rr3_reg  <= R2W'(r2_reg) * R2W'(r2_reg);

        sx4_reg   <= sx3_reg;
        sy4_reg   <= sy3_reg;
        ex4_reg   <= ex3_reg;
        dx4_reg   <= dx3_reg;
        dy4_reg   <= dy3_reg;
        rr4_reg   <= rr3_reg;
        l24_reg   <= $unsigned(pxx3_reg) + $unsigned(pyy3_reg);
        dot4_reg  <= {pdu3_reg[PW-1], pdu3_reg} + {pdv3_reg[PW-1], pdv3_reg};
        acrs4_reg <= crs4_next[DOTW-1] ? $unsigned(-crs4_next) : $unsigned(crs4_next);

        sx5_reg   <= sx4_reg;
        sy5_reg   <= sy4_reg;
        ex5_reg   <= ex4_reg;
        dx5_reg   <= dx4_reg;
        dy5_reg   <= dy4_reg;
        l25_reg   <= l24_reg;
        dot5_reg  <= dot4_reg;
        c25_reg   <= RADW'(acrs4_reg[ACW-1:0]) * RADW'(acrs4_reg[ACW-1:0]);
        // radius squared times length squared, split at the low word of l2
        r2l5_reg  <= RADW'(rr4_reg) * RADW'(l24_reg[ACW-1:0])
                     + ((RADW'(rr4_reg) * RADW'(l24_reg[L2W-1:ACW])) << ACW);
        far5_reg  <= |acrs4_reg[DOTW-1:ACW];
        zero5_reg <= l24_reg == '0;

        rad6_reg       <= lt5 ? (r2l5_reg - c25_reg) : '0;
        side6_reg.sx   <= sx5_reg;
        side6_reg.sy   <= sy5_reg;
        side6_reg.ex   <= ex5_reg;
        side6_reg.dx   <= dx5_reg;
        side6_reg.dy   <= dy5_reg;
        side6_reg.dot  <= dot5_reg;
        side6_reg.l2   <= l25_reg;
        side6_reg.cand <= !zero5_reg && !far5_reg && (lt5 || eq5);
        side6_reg.chk  <= lt5;
    end

    assign out_valid = valid_reg[FRONT_STAGES-1];
    assign out_rad   = rad6_reg;
    assign out_side  = side6_reg;

endmodule

// ----- rtl/scfh_sqrt.sv -----
// pipelined integer square root, two result bits per stage
module scfh_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [scfh_pkg::RADW-1:0]     in_rad,
    input  scfh_pkg::front_side_t         in_side,
    output logic                          out_valid,
    output logic [scfh_pkg::SQW-1:0]      out_root,
    output scfh_pkg::front_side_t         out_side
);
    import scfh_pkg::*;

    logic [SQRT_STAGES-1:0] valid_reg;
    sqrt_state_t            st_reg   [SQRT_STAGES];
    sqrt_state_t            st_next  [SQRT_STAGES];
    front_side_t            side_reg [SQRT_STAGES];

    always_comb
    begin
        sqrt_state_t cur;
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            if (s == 0)
            begin
                cur.v   = in_rad;
                cur.res = '0;
            end
            else
            begin
                cur = st_reg[s-1];
            end
            for (int j = 0; j < SQRT_PER; j++)
            begin
                cur = sqrt_step(cur, SQRT_PER * s + j);
            end
            st_next[s] = cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            st_reg[s]   <= st_next[s];
            side_reg[s] <= (s == 0) ? in_side : side_reg[s-1];
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_root  = st_reg[SQRT_STAGES-1].res[SQW-1:0];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

// ----- rtl/scfh_mid.sv -----
// projection offset, scaling by the direction and dividend setup
module scfh_mid (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [scfh_pkg::SQW-1:0]      in_root,
    input  scfh_pkg::front_side_t         in_side,
    output logic                          out_valid,
    output logic [scfh_pkg::NW-1:0]       out_nx,
    output logic [scfh_pkg::NW-1:0]       out_ny,
    output logic [scfh_pkg::DENW-1:0]     out_d,
    output scfh_pkg::back_side_t          out_side
);
    import scfh_pkg::*;

    logic [MID_STAGES-1:0] valid_reg;

    logic signed [KW-1:0]  k1_reg;
    logic signed [DW-1:0]  dx1_reg, dy1_reg;
    logic        [L2W-1:0] l21_reg, l22_reg;
    back_side_t            side1_reg, side2_reg, side3_reg;
    logic signed [MW-1:0]  px2_reg, py2_reg;
    logic [NW-1:0]         nx3_reg, ny3_reg;
    logic [DENW-1:0]       d3_reg;

    logic [MW-1:0] magx, magy;

    assign magx = px2_reg[MW-1] ? $unsigned(-px2_reg) : $unsigned(px2_reg);
    assign magy = py2_reg[MW-1] ? $unsigned(-py2_reg) : $unsigned(py2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[MID_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg         <= {in_side.dot[DOTW-1], in_side.dot} - {{(KW - SQW){1'b0}}, in_root};
        dx1_reg        <= in_side.dx;
        dy1_reg        <= in_side.dy;
        l21_reg        <= in_side.l2;
        side1_reg.sx   <= in_side.sx;
        side1_reg.sy   <= in_side.sy;
        side1_reg.ex   <= in_side.ex;
        side1_reg.negx <= 1'b0;
        side1_reg.negy <= 1'b0;
        side1_reg.cand <= in_side.cand;
        side1_reg.chk  <= in_side.chk;

        px2_reg   <= MW'(k1_reg) * MW'(dx1_reg);
        py2_reg   <= MW'(k1_reg) * MW'(dy1_reg);
        l22_reg   <= l21_reg;
        side2_reg <= side1_reg;

        // round to nearest: (2|p| + l2) / (2 l2)
        nx3_reg        <= {1'b0, magx, 1'b0} + NW'(l22_reg);
        ny3_reg        <= {1'b0, magy, 1'b0} + NW'(l22_reg);
        d3_reg         <= {l22_reg, 1'b0};
        side3_reg.sx   <= side2_reg.sx;
        side3_reg.sy   <= side2_reg.sy;
        side3_reg.ex   <= side2_reg.ex;
        side3_reg.cand <= side2_reg.cand;
        side3_reg.chk  <= side2_reg.chk;
        side3_reg.negx <= px2_reg[MW-1];
        side3_reg.negy <= py2_reg[MW-1];
    end

    assign out_valid = valid_reg[MID_STAGES-1];
    assign out_nx    = nx3_reg;
    assign out_ny    = ny3_reg;
    assign out_d     = d3_reg;
    assign out_side  = side3_reg;

endmodule

// ----- rtl/scfh_div.sv -----
// two-lane pipelined restoring divider, two quotient bits per stage
module scfh_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [scfh_pkg::NW-1:0]       in_nx,
    input  logic [scfh_pkg::NW-1:0]       in_ny,
    input  logic [scfh_pkg::DENW-1:0]     in_d,
    input  scfh_pkg::back_side_t          in_side,
    output logic                          out_valid,
    output logic [scfh_pkg::QW-1:0]       out_qx,
    output logic [scfh_pkg::QW-1:0]       out_qy,
    output scfh_pkg::back_side_t          out_side
);
    import scfh_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    div_state_t            x_reg    [DIV_STAGES];
    div_state_t            y_reg    [DIV_STAGES];
    div_state_t            x_next   [DIV_STAGES];
    div_state_t            y_next   [DIV_STAGES];
    logic [DENW-1:0]       d_reg    [DIV_STAGES];
    back_side_t            side_reg [DIV_STAGES];

    always_comb
    begin
        div_state_t      cx;
        div_state_t      cy;
        logic [DENW-1:0] dd;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                cx.rem = in_nx;
                cx.q   = '0;
                cy.rem = in_ny;
                cy.q   = '0;
                dd     = in_d;
            end
            else
            begin
                cx = x_reg[s-1];
                cy = y_reg[s-1];
                dd = d_reg[s-1];
            end
            for (int j = 0; j < DIV_PER; j++)
            begin
                cx = div_step(cx, dd, QW - 1 - (DIV_PER * s + j));
                cy = div_step(cy, dd, QW - 1 - (DIV_PER * s + j));
            end
            x_next[s] = cx;
            y_next[s] = cy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            x_reg[s]    <= x_next[s];
            y_reg[s]    <= y_next[s];
            d_reg[s]    <= (s == 0) ? in_d : d_reg[s-1];
            side_reg[s] <= (s == 0) ? in_side : side_reg[s-1];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_qx    = x_reg[DIV_STAGES-1].q;
    assign out_qy    = y_reg[DIV_STAGES-1].q;
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// ----- rtl/segment_circle_first_hit_core.sv -----
// top level of the segment circle first hit core
// a word accepted on start passes the front, root, mid and divider stages and the result register before done
// throughput: one word per cycle; busy is never raised, since every stage moves each cycle
// results leave on done for exactly one cycle; the receiver cannot stall
// the longest parts of the pipe are the 16-stage root and the 9-stage two-lane divider
// reset clears all stage valid bits at once; no word in flight survives it
module segment_circle_first_hit_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  scfh_pkg::in_word_t   query,
    output logic                 done,
    output scfh_pkg::out_word_t  result
);
    import scfh_pkg::*;

    // front: differences, products, l2, dot, cross, radicand
    logic             f_valid;
    logic [RADW-1:0]  f_rad;
    front_side_t      f_side;

    // root of r^2 l2 - cross^2, zero in the tangent case
    logic             s_valid;
    logic [SQW-1:0]   s_root;
    front_side_t      s_side;

    // scaled offsets and rounding dividends
    logic             m_valid;
    logic [NW-1:0]    m_nx, m_ny;
    logic [DENW-1:0]  m_d;
    back_side_t       m_side;

    // rounded offsets along x and y
    logic             d_valid;
    logic [QW-1:0]    d_qx, d_qy;
    back_side_t       d_side;

    logic                  done_reg;
    out_word_t             result_reg;
    logic signed [FXW-1:0] offx, offy, fx, fy, sxe, exe, sye;
    logic                  bad;
    logic                  hit_next;

    // no back-pressure anywhere in the pipe
    assign busy = 1'b0;

    scfh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_word   (query),
        .out_valid (f_valid),
        .out_rad   (f_rad),
        .out_side  (f_side)
    );

    scfh_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_rad    (f_rad),
        .in_side   (f_side),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_side  (s_side)
    );

    scfh_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_root   (s_root),
        .in_side   (s_side),
        .out_valid (m_valid),
        .out_nx    (m_nx),
        .out_ny    (m_ny),
        .out_d     (m_d),
        .out_side  (m_side)
    );

    scfh_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid),
        .in_nx     (m_nx),
        .in_ny     (m_ny),
        .in_d      (m_d),
        .in_side   (m_side),
        .out_valid (d_valid),
        .out_qx    (d_qx),
        .out_qy    (d_qy),
        .out_side  (d_side)
    );

    // apply the sign of each offset and add the start point
    assign offx = d_side.negx ? -FXW'(d_qx) : FXW'(d_qx);
    assign offy = d_side.negy ? -FXW'(d_qy) : FXW'(d_qy);
    assign sxe  = FXW'(d_side.sx);
    assign sye  = FXW'(d_side.sy);
    assign exe  = FXW'(d_side.ex);
    assign fx   = sxe + offx;
    assign fy   = sye + offy;

    // x range check on the unsaturated point; vertical segments pass
    assign bad = ((exe < sxe) && ((fx > sxe) || (fx < exe)))
              || ((exe > sxe) && ((fx < sxe) || (fx > exe)));

    // tangent points skip the range check
    assign hit_next = d_side.cand && !(d_side.chk && bad);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.hit     <= hit_next;
        result_reg.point_x <= hit_next ? sat_coord(fx) : '0;
        result_reg.point_y <= hit_next ? sat_coord(fy) : '0;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/scfh_checker.sv -----
// port-level checker for the segment circle first hit core and its bind
`include "segment_circle_first_hit_core_macros.svh"

module scfh_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  scfh_pkg::in_word_t   query,
    input  logic                 done,
    input  scfh_pkg::out_word_t  result
);
    import scfh_pkg::*;

    logic acc;
    logic degen;
    logic zero_pt;

    assign acc     = start && !busy;
    assign degen   = acc && (query.start_x == query.end_x) && (query.start_y == query.end_y);
    assign zero_pt = (result.point_x == '0) && (result.point_y == '0);

    // every accepted word comes back after the fixed latency
    `SCFH_ASSERT_DELAY(a_latency, acc, LATENCY, done)

    // no strobe without a word accepted the same latency earlier
    `SCFH_ASSERT_IMPL(a_no_extra, done, $past(acc, LATENCY))

    // a miss reports the origin
    `SCFH_ASSERT_IMPL(a_miss_zero, done && !result.hit, zero_pt)

    // a zero-length segment never hits
    `SCFH_ASSERT_DELAY(a_degenerate, degen, LATENCY, !result.hit)

endmodule

bind segment_circle_first_hit_core scfh_checker u_scfh_checker (.*);

// ----- dv/tb.sv -----
// self-checking testbench for the segment circle first hit core
`timescale 1ns / 1ps

module tb;

    import scfh_pkg::*;

    localparam int IN_BITS = $bits(in_word_t);

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  query;
    logic      done;
    out_word_t result;

    // expected result words, oldest first
    out_word_t hit_queue[$];
    int        errs;

    // one directed row: the query, and an expected word where it is obvious
    typedef struct {
        in_word_t  q;
        bit        known;
        out_word_t e;
    } dir_row_t;

    dir_row_t dir_rows[$];

    segment_circle_first_hit_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .query  (query),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // num / den rounded to nearest, ties away from zero
    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned quo;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        quo = (2 * mag + den) / (2 * den);
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[CW-1:0];
    endfunction

    // first crossing or tangent point of one query
    function automatic out_word_t first_hit(in_word_t q);
        longint          sx, sy, ex, ey, cx, cy, dx, dy, ux, uy, dot, crs, s, k, fx, fy;
        longint unsigned rr, l2, acrs, c2, r2l;
        bit              found, bad;
        out_word_t       o;
        sx = longint'($signed(q.start_x));
        sy = longint'($signed(q.start_y));
        ex = longint'($signed(q.end_x));
        ey = longint'($signed(q.end_y));
        cx = longint'($signed(q.centre_x));
        cy = longint'($signed(q.centre_y));
        rr = longint'(q.radius);
        dx = ex - sx;
        dy = ey - sy;
        ux = cx - sx;
        uy = cy - sy;
        l2   = dx * dx + dy * dy;
        dot  = dx * ux + dy * uy;
        crs  = dx * uy - dy * ux;
        acrs = (crs < 0) ? -crs : crs;
        found = 1'b0;
        fx = 0;
        fy = 0;
        o  = '0;
        if (l2 == 0 || acrs >= (64'd1 << 32))
            return o;
        c2  = acrs * acrs;
        r2l = rr * rr * l2;
        if (c2 < r2l)
        begin
            // nearer crossing along start to end
            s  = longint'(int_sqrt(r2l - c2));
            k  = dot - s;
            fx = sx + round_div(k * dx, l2);
            fy = sy + round_div(k * dy, l2);
            bad = (ex < sx && (fx > sx || fx < ex)) || (ex > sx && (fx < sx || fx > ex));
            found = !bad;
        end
        else if (c2 == r2l)
        begin
            // tangent point, no range check
            fx = sx + round_div(dot * dx, l2);
            fy = sy + round_div(dot * dy, l2);
            found = 1'b1;
        end
        if (found)
        begin
            o.hit     = 1'b1;
            o.point_x = clamp_coord(fx);
            o.point_y = clamp_coord(fy);
        end
        return o;
    endfunction

    task automatic add_row(input int a, b, c, d, e, f, r, input bit known,
                           input bit h, input int px, input int py);
        dir_row_t row;
        row.q.start_x  = CW'(a);
        row.q.start_y  = CW'(b);
        row.q.end_x    = CW'(c);
        row.q.end_y    = CW'(d);
        row.q.centre_x = CW'(e);
        row.q.centre_y = CW'(f);
        row.q.radius   = RW'(r);
        row.known      = known;
        row.e.hit      = h;
        row.e.point_x  = CW'(px);
        row.e.point_y  = CW'(py);
        dir_rows.push_back(row);
    endtask

    function automatic logic signed [CW-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'sh0001;
            default: return 16'shffff;
        endcase
    endfunction

    // random query: mostly small geometry near the circle, some noise and extremes
    function automatic in_word_t random_query();
        in_word_t q;
        int       sx, sy, ex, ey, cx, cy;
        int       mode;
        mode = int'($urandom_range(0, 9));
        if (mode < 2)
        begin
            q = IN_BITS'({$urandom, $urandom, $urandom, $urandom});
        end
        else if (mode == 2)
        begin
            q.start_x  = pick_extreme();
            q.start_y  = pick_extreme();
            q.end_x    = pick_extreme();
            q.end_y    = pick_extreme();
            q.centre_x = pick_extreme();
            q.centre_y = pick_extreme();
            q.radius   = ($urandom_range(0, 1) == 1) ? 15'h7fff : RW'($urandom);
        end
        else
        begin
            sx = int'($urandom_range(0, 6000)) - 3000;
            sy = int'($urandom_range(0, 6000)) - 3000;
            ex = int'($urandom_range(0, 6000)) - 3000;
            ey = int'($urandom_range(0, 6000)) - 3000;
            case ($urandom_range(0, 7))
                0, 1: ey = sy;    // horizontal, used for tangents below
                2: ex = sx;       // vertical, no range check
                3: ex = sx + int'($urandom_range(0, 2)) - 1;
                default: ;
            endcase
            cx = (sx + ex) / 2 + int'($urandom_range(0, 1600)) - 800;
            cy = (sy + ey) / 2 + int'($urandom_range(0, 1600)) - 800;
            q.start_x  = CW'(sx);
            q.start_y  = CW'(sy);
            q.end_x    = CW'(ex);
            q.end_y    = CW'(ey);
            q.centre_x = CW'(cx);
            q.centre_y = CW'(cy);
            q.radius   = RW'($urandom_range(0, 2000));
            if (ey == sy && $urandom_range(0, 1) == 1)
                q.radius = (cy > sy) ? RW'(cy - sy) : RW'(sy - cy);
        end
        return q;
    endfunction

    // drive one word and hold it until the core takes it
    task automatic send_word(input in_word_t q);
        int gap;
        gap = int'($urandom_range(0, 99));
        if (gap < 70)
            gap = 0;
        else if (gap < 95)
            gap = int'($urandom_range(1, 3));
        else
            gap = int'($urandom_range(10, 40));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        query <= q;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        hit_queue.push_back(first_hit(q));
    endtask

    // result checker: every done strobe pops the oldest expected word
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && done)
        begin
            if (hit_queue.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, result);
                errs++;
            end
            else
            begin
                want = hit_queue.pop_front();
                if (result.hit !== want.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, result.hit);
                    errs++;
                end
                if (result.point_x !== want.point_x)
                begin
                    $display("%0t: point_x expected %0d actual %0d", $time,
                             want.point_x, result.point_x);
                    errs++;
                end
                if (result.point_y !== want.point_y)
                begin
                    $display("%0t: point_y expected %0d actual %0d", $time,
                             want.point_y, result.point_y);
                    errs++;
                end
            end
        end
    end

    initial
    begin
        errs  = 0;
        rst_n = 1'b0;
        start = 1'b0;
        query = '0;

        // zero-length segments never hit
        add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(32767, 32767, 32767, 32767, -32768, -32768, 32767, 1, 0, 0, 0);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 1, 0, 0, 0);
        // tangent on a horizontal segment
        add_row(0, 0, 160, 0, 80, 16, 16, 1, 1, 80, 0);
        // crossing outside the x range of the segment is dropped
        add_row(0, 0, 16, 0, 160, 0, 32, 1, 0, 0, 0);
        // plain crossings, both directions
        add_row(0, 0, 160, 0, 80, 0, 32, 0, 0, 0, 0);
        add_row(160, 0, 0, 0, 80, 0, 32, 0, 0, 0, 0);
        add_row(0, 0, 160, 160, 80, 40, 64, 0, 0, 0, 0);
        // vertical segment, no range check
        add_row(0, 0, 0, 160, 0, 80, 32, 0, 0, 0, 0);
        add_row(0, 0, 0, 16, 0, 500, 32, 0, 0, 0, 0);
        // tangent without range check, far off the segment
        add_row(0, 0, 16, 0, 3000, 100, 100, 0, 0, 0, 0);
        // extremes and saturation of the point
        add_row(-32768, -32768, 32767, 32767, 32767, -32768, 32767, 0, 0, 0, 0);
        add_row(-32768, 32767, 32767, -32768, 32767, 32767, 32767, 0, 0, 0, 0);
        add_row(32767, 0, 32766, 0, -32768, 0, 32767, 0, 0, 0, 0);
        add_row(-32768, 0, 32767, 0, 32767, 32767, 32767, 0, 0, 0, 0);
        add_row(-32768, -32768, 32767, -32767, 0, 0, 32767, 0, 0, 0, 0);
        add_row(1, 1, -1, -1, 0, 0, 1, 0, 0, 0, 0);
        add_row(100, 100, 101, 100, 100, 100, 0, 0, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].known && first_hit(dir_rows[i].q) !== dir_rows[i].e)
            begin
                $display("%0t: directed row %0d expected %h actual %h", $time, i,
                         dir_rows[i].e, first_hit(dir_rows[i].q));
                errs++;
            end
            send_word(dir_rows[i].q);
        end

        for (int n = 0; n < 1800; n++)
        begin
            if (n == 900)
            begin
                // drain the pipe once before going on
                start <= 1'b0;
                while (hit_queue.size() != 0)
                    @(posedge clk);
            end
            send_word(random_query());
        end
        start <= 1'b0;

        while (hit_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (errs == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
